>>> rtl/frame_rotate_grey_engine_defines.svh
// assertion macros for the frame rotate and greyscale engine
`ifndef FRAME_ROTATE_GREY_ENGINE_DEFINES_SVH
`define FRAME_ROTATE_GREY_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, clocked on clk and quiet during reset
`define FRGE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define FRGE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define FRGE_ASSERT_NOW(lbl, ante, cons, msg)
`define FRGE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/frge_pkg.sv
// shared types, constants and helpers for the frame rotate and greyscale engine
package frge_pkg;

	localparam int MAX_DIM  = 256;
	localparam int DIM_W    = $clog2(MAX_DIM);
	localparam int SIZE_W   = DIM_W + 1;
	localparam int DEPTH    = MAX_DIM * MAX_DIM;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int LCNT_W   = ADDR_W + 1;
	localparam int LIN_W    = DIM_W + SIZE_W;
	localparam int CFG_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int PIX_W    = 32;
	localparam int PROD_W   = 24;

	localparam logic [15:0] LUMA_R = 16'd19595;
	localparam logic [15:0] LUMA_G = 16'd38470;
	localparam logic [15:0] LUMA_B = 16'd7471;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH    = 2'd0,
		CFG_HEIGHT   = 2'd1,
		CFG_ROTATION = 2'd2,
		CFG_GREY     = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ROT_0   = 2'd0,
		ROT_90  = 2'd1,
		ROT_180 = 2'd2,
		ROT_270 = 2'd3
	} rot_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADDR,
		ST_READ,
		ST_MUL,
		ST_FIN
	} ctl_state_t;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef struct packed {
		logic       op;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} req_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
		logic       last_pixel;
		logic       status;
	} rsp_t;

	typedef struct packed {
		logic accept;
		logic addr_en;
		logic rd_en;
		logic mul_en;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic frame_loaded;
	} stat_t;

	// zero acts as one, oversize clamps to the largest frame
	function automatic logic [SIZE_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = SIZE_W'(MAX_DIM);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

endpackage

>>> rtl/frge_ram.sv
// generic simple dual-port ram with registered read
module frge_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/frge_ctrl.sv
// controller state machine: sequences loads, fetches and the output register
module frge_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_op,
	output logic              req_stall,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  frge_pkg::stat_t   status,
	output frge_pkg::cmd_t    cmd
);

	frge_pkg::ctl_state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= frge_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			frge_pkg::ST_IDLE: begin
				if (req_valid && (req_op == frge_pkg::OP_FETCH)) begin
					// an early fetch goes straight to the error beat
					state_d = status.frame_loaded ? frge_pkg::ST_ADDR : frge_pkg::ST_FIN;
				end
			end
			frge_pkg::ST_ADDR: state_d = frge_pkg::ST_READ;
			frge_pkg::ST_READ: state_d = frge_pkg::ST_MUL;
			frge_pkg::ST_MUL:  state_d = frge_pkg::ST_FIN;
			frge_pkg::ST_FIN: begin
				if (!out_valid_q || !rsp_stall) begin
					state_d = frge_pkg::ST_IDLE;
				end
			end
			default: state_d = frge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_stall = 1'b1;
		case (state_q)
			frge_pkg::ST_IDLE: begin
				req_stall  = 1'b0;
				cmd.accept = req_valid;
			end
			frge_pkg::ST_ADDR: cmd.addr_en = 1'b1;
			frge_pkg::ST_READ: cmd.rd_en   = 1'b1;
			frge_pkg::ST_MUL:  cmd.mul_en  = 1'b1;
			frge_pkg::ST_FIN:  cmd.out_load = !out_valid_q || !rsp_stall;
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	assign rsp_valid = out_valid_q;

endmodule

>>> rtl/frge_dp.sv
// datapath: config registers, counters, address math, frame store and luma
module frge_dp (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frge_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frge_pkg::CFG_W-1:0]      cfg_data,
	input  frge_pkg::req_t                  req,
	input  frge_pkg::cmd_t                  cmd,
	output frge_pkg::stat_t                 status,
	output frge_pkg::rsp_t                  rsp
);

	logic [frge_pkg::SIZE_W-1:0] w_q, h_q;
	frge_pkg::rot_t              rot_q;
	logic                        grey_q;
	logic [frge_pkg::LCNT_W-1:0] load_count_q;
	logic                        loaded_q;
	logic [frge_pkg::DIM_W-1:0]  col_q, row_q;
	logic                        err_q;

	logic [frge_pkg::ADDR_W-1:0] addr_s1;
	logic                        last_s1;
	logic [frge_pkg::PROD_W-1:0] prod_r_s3, prod_g_s3, prod_b_s3;

	logic [frge_pkg::LCNT_W-1:0] total;
	logic [frge_pkg::LCNT_W-1:0] load_next;
	logic                        load_we;
	logic [frge_pkg::SIZE_W-1:0] ow, oh;
	logic [frge_pkg::SIZE_W-1:0] col_x, row_x;
	logic [frge_pkg::DIM_W-1:0]  sx, sy;
	logic [frge_pkg::LIN_W-1:0]  lin;
	logic [frge_pkg::PIX_W-1:0]  pix;
	logic [frge_pkg::PROD_W:0]   luma_sum;
	logic [7:0]                  luma;
	logic                        is_last;

	assign total     = frge_pkg::LCNT_W'(w_q) * frge_pkg::LCNT_W'(h_q);
	assign load_next = load_count_q + frge_pkg::LCNT_W'(1);
	assign load_we   = cmd.accept && (req.op == frge_pkg::OP_LOAD) && !loaded_q
		&& (load_count_q < total);

	assign col_x = frge_pkg::SIZE_W'(col_q);
	assign row_x = frge_pkg::SIZE_W'(row_q);

	always_comb begin
		if ((rot_q == frge_pkg::ROT_90) || (rot_q == frge_pkg::ROT_270)) begin
			ow = h_q;
			oh = w_q;
		end else begin
			ow = w_q;
			oh = h_q;
		end
	end

	// inverse rotation: destination position back to source pixel
	always_comb begin
		case (rot_q)
			frge_pkg::ROT_90: begin
				sx = row_q;
				sy = frge_pkg::DIM_W'(h_q - frge_pkg::SIZE_W'(1) - col_x);
			end
			frge_pkg::ROT_180: begin
				sx = frge_pkg::DIM_W'(w_q - frge_pkg::SIZE_W'(1) - col_x);
				sy = frge_pkg::DIM_W'(h_q - frge_pkg::SIZE_W'(1) - row_x);
			end
			frge_pkg::ROT_270: begin
				sx = frge_pkg::DIM_W'(w_q - frge_pkg::SIZE_W'(1) - row_x);
				sy = col_q;
			end
			default: begin
				sx = col_q;
				sy = row_q;
			end
		endcase
	end

	assign lin = frge_pkg::LIN_W'(sy) * frge_pkg::LIN_W'(w_q) + frge_pkg::LIN_W'(sx);
	assign is_last = (col_x == ow - frge_pkg::SIZE_W'(1)) && (row_x == oh - frge_pkg::SIZE_W'(1));

	frge_ram #(
		.WIDTH (frge_pkg::PIX_W),
		.DEPTH (frge_pkg::DEPTH)
	) u_store (
		.clk   (clk),
		.we    (load_we),
		.waddr (load_count_q[frge_pkg::ADDR_W-1:0]),
		.wdata ({req.alpha_in, req.blue_in, req.green_in, req.red_in}),
		.re    (cmd.rd_en),
		.raddr (addr_s1),
		.rdata (pix)
	);

	assign luma_sum = (frge_pkg::PROD_W+1)'(prod_r_s3) + (frge_pkg::PROD_W+1)'(prod_g_s3)
		+ (frge_pkg::PROD_W+1)'(prod_b_s3);
	assign luma = luma_sum[23:16];

	// config, counters and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q          <= frge_pkg::SIZE_W'(1);
			h_q          <= frge_pkg::SIZE_W'(1);
			rot_q        <= frge_pkg::ROT_0;
			grey_q       <= 1'b0;
			load_count_q <= '0;
			loaded_q     <= 1'b0;
			col_q        <= '0;
			row_q        <= '0;
			err_q        <= 1'b0;
		end else if (cfg_we) begin
			case (frge_pkg::cfg_idx_t'(cfg_index))
				frge_pkg::CFG_WIDTH: begin
					w_q          <= frge_pkg::eff_dim(cfg_data);
					load_count_q <= '0;
					loaded_q     <= 1'b0;
					col_q        <= '0;
					row_q        <= '0;
				end
				frge_pkg::CFG_HEIGHT: begin
					h_q          <= frge_pkg::eff_dim(cfg_data);
					load_count_q <= '0;
					loaded_q     <= 1'b0;
					col_q        <= '0;
					row_q        <= '0;
				end
				frge_pkg::CFG_ROTATION: begin
					rot_q <= frge_pkg::rot_t'(cfg_data[1:0]);
					col_q <= '0;
					row_q <= '0;
				end
				frge_pkg::CFG_GREY: grey_q <= cfg_data[0];
				default: grey_q <= grey_q;
			endcase
		end else begin
			if (cmd.accept && (req.op == frge_pkg::OP_FETCH)) begin
				err_q <= !loaded_q;
			end
			if (load_we) begin
				load_count_q <= load_next;
				if (load_next >= total) begin
					loaded_q <= 1'b1;
				end
			end
			if (cmd.out_load && !err_q) begin
				if (last_s1) begin
					// frame fully read out, release it for the next one
					load_count_q <= '0;
					loaded_q     <= 1'b0;
					col_q        <= '0;
					row_q        <= '0;
				end else if (col_x + frge_pkg::SIZE_W'(1) >= ow) begin
					col_q <= '0;
					row_q <= row_q + frge_pkg::DIM_W'(1);
				end else begin
					col_q <= col_q + frge_pkg::DIM_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.addr_en) begin
			addr_s1 <= lin[frge_pkg::ADDR_W-1:0];
			last_s1 <= is_last;
		end
		if (cmd.mul_en) begin
			prod_r_s3 <= frge_pkg::PROD_W'(frge_pkg::LUMA_R) * frge_pkg::PROD_W'(pix[7:0]);
			prod_g_s3 <= frge_pkg::PROD_W'(frge_pkg::LUMA_G) * frge_pkg::PROD_W'(pix[15:8]);
			prod_b_s3 <= frge_pkg::PROD_W'(frge_pkg::LUMA_B) * frge_pkg::PROD_W'(pix[23:16]);
		end
		if (cmd.out_load) begin
			if (err_q) begin
				rsp.red_out    <= 8'd0;
				rsp.green_out  <= 8'd0;
				rsp.blue_out   <= 8'd0;
				rsp.alpha_out  <= 8'd0;
				rsp.last_pixel <= 1'b0;
				rsp.status     <= 1'b1;
			end else begin
				rsp.red_out    <= grey_q ? luma : pix[7:0];
				rsp.green_out  <= grey_q ? luma : pix[15:8];
				rsp.blue_out   <= grey_q ? luma : pix[23:16];
				rsp.alpha_out  <= pix[31:24];
				rsp.last_pixel <= last_s1;
				rsp.status     <= 1'b0;
			end
		end
	end

	assign status.frame_loaded = loaded_q;

endmodule

>>> rtl/frame_rotate_grey_engine.sv
// top level: rgba frame store with 0/90/180/270 rotation and luma greyscale
// loads: one beat per cycle while no fetch is in progress, no result
// fetch: result passes through address, store read, multiply and sum into the output register;
//   no new request is taken until that result has been loaded into the output register
// early fetch (frame not loaded): error result loaded straight from ST_FIN, skipping address, read and multiply
// reset: config to 1x1, no rotation, grey off; counters cleared; frame store not cleared
`include "frame_rotate_grey_engine_defines.svh"

module frame_rotate_grey_engine (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [frge_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [frge_pkg::CFG_W-1:0]      cfg_data,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  frge_pkg::req_t                  req,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output frge_pkg::rsp_t                  rsp
);

	frge_pkg::cmd_t  cmd;
	frge_pkg::stat_t status;

	frge_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.status    (status),
		.cmd       (cmd)
	);

	frge_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp       (rsp)
	);

	// an error beat carries nothing but the status bit
	`FRGE_ASSERT_NOW(a_err_beat_clean, rsp_valid && rsp.status, (rsp.red_out == 8'd0) && (rsp.green_out == 8'd0) && (rsp.blue_out == 8'd0) && (rsp.alpha_out == 8'd0) && !rsp.last_pixel, "error beat with nonzero payload")
	// a fetch keeps the input side busy on the following cycle
	`FRGE_ASSERT_NEXT(a_fetch_busy, req_valid && !req_stall && (req.op == frge_pkg::OP_FETCH), req_stall, "input taken right after a fetch")
	// output valid only rises from a result load
	`FRGE_ASSERT_NOW(a_valid_from_load, $rose(rsp_valid), $past(cmd.out_load), "result appeared without a load")

endmodule

>>> test/frame_rotate_grey_engine_test.sv
// self-checking testbench for the rgba frame rotation and greyscale engine
`timescale 1ns / 100ps

module frame_rotate_grey_engine_test;
	import frge_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int TARGET_BEATS = 1550;
	localparam int HOLD_CYCLES = 300;

	// predicts each fetched pixel from its own copy of the frame store and registers
	class frame_rotation_board;
		localparam int unsigned W_RED = 19595;
		localparam int unsigned W_GREEN = 38470;
		localparam int unsigned W_BLUE = 7471;

		bit [31:0]   pixel_mem [DEPTH];
		int unsigned fill_count;
		bit          frame_full;
		int unsigned col;
		int unsigned row;
		logic [8:0]  width_reg;
		logic [8:0]  height_reg;
		rot_t        rot;
		bit          grey;
		rsp_t        pixels_due [$];
		int          fault_count;
		int          pixels_checked;

		function new();
			restart();
			width_reg = 9'd1;
			height_reg = 9'd1;
			rot = ROT_0;
			grey = 1'b0;
			fault_count = 0;
			pixels_checked = 0;
		endfunction

		function void restart();
			fill_count = 0;
			frame_full = 1'b0;
			col = 0;
			row = 0;
		endfunction

		function int unsigned dim_of(logic [8:0] v);
			if (v == 9'd0) return 1;
			if (v > 9'd256) return 256;
			return int'(v);
		endfunction

		function void write_reg(cfg_idx_t idx, logic [8:0] val);
			case (idx)
				CFG_WIDTH: begin
					width_reg = val;
					restart();
				end
				CFG_HEIGHT: begin
					height_reg = val;
					restart();
				end
				CFG_ROTATION: begin
					rot = rot_t'(val[1:0]);
					col = 0;
					row = 0;
				end
				default: begin
					grey = val[0];
				end
			endcase
		endfunction

		function void take_request(req_t item);
			int unsigned w, h, total, ow, oh, sx, sy, luma;
			bit [31:0] px;
			rsp_t want;
			w = dim_of(width_reg);
			h = dim_of(height_reg);
			total = w * h;
			if (item.op == OP_LOAD) begin
				if (!frame_full && fill_count < total) begin
					pixel_mem[fill_count] = {item.alpha_in, item.blue_in, item.green_in, item.red_in};
					fill_count++;
					if (fill_count >= total) frame_full = 1'b1;
				end
				return;
			end
			want = '0;
			if (!frame_full) begin
				want.status = 1'b1;
				pixels_due.push_back(want);
				return;
			end
			if (rot == ROT_90 || rot == ROT_270) begin
				ow = h;
				oh = w;
			end else begin
				ow = w;
				oh = h;
			end
			if (col >= ow) col = 0;
			if (row >= oh) row = 0;
			case (rot)
				ROT_90: begin
					sx = row;
					sy = h - 1 - col;
				end
				ROT_180: begin
					sx = w - 1 - col;
					sy = h - 1 - row;
				end
				ROT_270: begin
					sx = w - 1 - row;
					sy = col;
				end
				default: begin
					sx = col;
					sy = row;
				end
			endcase
			px = pixel_mem[(sy * w + sx) % DEPTH];
			want.red_out = px[7:0];
			want.green_out = px[15:8];
			want.blue_out = px[23:16];
			want.alpha_out = px[31:24];
			if (grey) begin
				luma = (W_RED * px[7:0] + W_GREEN * px[15:8] + W_BLUE * px[23:16]) >> 16;
				want.red_out = luma[7:0];
				want.green_out = luma[7:0];
				want.blue_out = luma[7:0];
			end
			want.last_pixel = (col == ow - 1) && (row == oh - 1);
			pixels_due.push_back(want);
			if (want.last_pixel) begin
				restart();
			end else if (col + 1 >= ow) begin
				col = 0;
				row++;
			end else begin
				col++;
			end
		endfunction

		function void check_pixel(rsp_t got);
			rsp_t want;
			bit bad;
			if (pixels_due.size() == 0) begin
				fault_count++;
				if (fault_count <= 10) $display("unexpected result beat %h", got);
				return;
			end
			want = pixels_due.pop_front();
			pixels_checked++;
			bad = (got.red_out !== want.red_out) || (got.green_out !== want.green_out)
				|| (got.blue_out !== want.blue_out) || (got.alpha_out !== want.alpha_out)
				|| (got.last_pixel !== want.last_pixel) || (got.status !== want.status);
			if (bad) begin
				fault_count++;
				if (fault_count <= 10) begin
					$display("mismatch at result %0d: rgba %h %h %h %h last %b status %b,",
						pixels_checked, want.red_out, want.green_out, want.blue_out,
						want.alpha_out, want.last_pixel, want.status);
					$display("  got rgba %h %h %h %h last %b status %b",
						got.red_out, got.green_out, got.blue_out, got.alpha_out,
						got.last_pixel, got.status);
				end
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;

	frame_rotation_board board = new();
	bit tx_calm;
	bit rx_calm;
	int hold_request;
	int item_count;
	int frames_done;
	int cycle_count;

	frame_rotate_grey_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [8:0] pick_dim();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 9'd0;
		if (r < 8) return 9'($urandom_range(1, 6));
		return 9'($urandom_range(7, 16));
	endfunction

	function automatic req_t make_req(op_t op);
		req_t r;
		r.op = op;
		{r.alpha_in, r.blue_in, r.green_in, r.red_in} = $urandom();
		return r;
	endfunction

	task automatic drive_req(input req_t item);
		int gap;
		gap = tx_calm ? 0 : pick_gap();
		repeat (gap) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
		@(negedge clk);
		req_valid = 1'b1;
		req = item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.take_request(item);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(posedge clk);
		board.write_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// drop valid, wait for every pending pixel, then let a trailing load finish
	task automatic settle();
		@(negedge clk);
		req_valid = 1'b0;
		while (board.pixels_due.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic fetch_run(input int unsigned n, input bit no_noise);
		for (int unsigned i = 0; i < n; i++) begin
			// load while the frame is complete: dropped by the block
			if (!no_noise && $urandom_range(0, 15) == 0) drive_req(make_req(OP_LOAD));
			drive_req(make_req(OP_FETCH));
			item_count++;
		end
	endtask

	task automatic run_frame(input logic [8:0] wv, input logic [8:0] hv, input rot_t rot_v,
		input bit grey_v, input bit squeeze);
		int unsigned total;
		int unsigned part;
		settle();
		write_reg(CFG_WIDTH, wv);
		write_reg(CFG_HEIGHT, hv);
		write_reg(CFG_ROTATION, 9'(rot_v));
		write_reg(CFG_GREY, 9'(grey_v));
		total = board.dim_of(wv) * board.dim_of(hv);
		for (int unsigned i = 0; i < total; i++) begin
			if ($urandom_range(0, 15) == 0) begin
				drive_req(make_req(OP_FETCH));
				item_count++;
			end
			drive_req(make_req(OP_LOAD));
			item_count++;
		end
		if (squeeze) begin
			// receiver holds off while fetches keep coming back to back
			tx_calm = 1'b1;
			hold_request = HOLD_CYCLES;
		end
		part = 0;
		if (!squeeze && total > 1 && $urandom_range(0, 3) == 0) part = $urandom_range(1, total - 1);
		if (part != 0) begin
			fetch_run(part, 1'b0);
			settle();
			// frame kept, fetch position back to the start
			write_reg(CFG_ROTATION, 9'($urandom_range(0, 3)));
			if ($urandom_range(0, 1) == 1) write_reg(CFG_GREY, 9'($urandom_range(0, 1)));
		end
		fetch_run(total, squeeze);
		frames_done++;
	endtask

	// result side
	initial begin
		int stall_left;
		rsp_stall = 1'b0;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left > 0) begin
				rsp_stall = 1'b1;
				stall_left--;
			end else begin
				rsp_stall = 1'b0;
				if (!rx_calm) stall_left = pick_gap();
			end
			@(posedge clk);
			if (rsp_valid && !rsp_stall) board.check_pixel(rsp);
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL frame_rotate_grey_engine");
		$finish;
	end

	initial begin
		req_t p;
		logic [8:0] big_dim;
		logic [8:0] thin_dim;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_WIDTH;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		hold_request = 0;
		item_count = 0;
		frames_done = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset size 1x1: early fetch, full-scale pixel, ignored load, fetch, early again
		drive_req(make_req(OP_FETCH));
		p = make_req(OP_LOAD);
		{p.alpha_in, p.blue_in, p.green_in, p.red_in} = '1;
		drive_req(p);
		drive_req(make_req(OP_LOAD));
		drive_req(make_req(OP_FETCH));
		drive_req(make_req(OP_FETCH));

		// 2x3 at 90 degrees with luma, then rotation change mid-image
		settle();
		write_reg(CFG_WIDTH, 9'd2);
		write_reg(CFG_HEIGHT, 9'd3);
		write_reg(CFG_ROTATION, 9'(ROT_90));
		write_reg(CFG_GREY, 9'd1);
		p = make_req(OP_LOAD);
		{p.alpha_in, p.blue_in, p.green_in, p.red_in} = '0;
		drive_req(p);
		{p.alpha_in, p.blue_in, p.green_in, p.red_in} = '1;
		drive_req(p);
		repeat (4) drive_req(make_req(OP_LOAD));
		repeat (2) drive_req(make_req(OP_FETCH));
		settle();
		write_reg(CFG_ROTATION, 9'(ROT_180));
		repeat (6) drive_req(make_req(OP_FETCH));

		while (item_count < TARGET_BEATS) begin
			settle();
			tx_calm = ($urandom_range(0, 5) == 0);
			rx_calm = tx_calm;
			if (frames_done == 0) begin
				// widest source, zero height acting as one
				run_frame(9'd511, 9'd0, rot_t'($urandom_range(0, 3)), 1'b1, 1'b0);
			end else if (frames_done == 1) begin
				run_frame(9'd1, 9'd256, ROT_270, 1'b0, 1'b0);
			end else if (frames_done == 3) begin
				run_frame(9'd8, 9'd8, rot_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), 1'b1);
			end else if ($urandom_range(0, 39) == 0) begin
				big_dim = ($urandom_range(0, 1) == 1) ? 9'd256 : 9'($urandom_range(257, 511));
				thin_dim = 9'($urandom_range(0, 1));
				if ($urandom_range(0, 1) == 1)
					run_frame(big_dim, thin_dim, rot_t'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), 1'b0);
				else
					run_frame(thin_dim, big_dim, rot_t'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), 1'b0);
			end else begin
				run_frame(pick_dim(), pick_dim(), rot_t'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), 1'b0);
			end
		end

		tx_calm = 1'b0;
		rx_calm = 1'b0;
		settle();
		if (board.pixels_due.size() != 0) board.fault_count++;
		$display("covered %0d frames over all four rotations, grey on and off, clamped sizes",
			frames_done);
		$display("%0d request beats sent, %0d result beats checked, %0d faults",
			item_count, board.pixels_checked, board.fault_count);
		if (board.fault_count == 0) begin
			$display("PASS frame_rotate_grey_engine");
		end else begin
			$display("FAIL frame_rotate_grey_engine");
		end
		$finish;
	end

endmodule
